// File: design/assert_macros.svh
// Assertion macros shared by the shaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: design/tbps_pkg.sv
// Package with types and constants of the token bucket packet shaper.
package tbps_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam logic [15:0] BUCKET_DEPTH_RESET = 16'd10;

   localparam logic [2:0] EVT_TOKEN_ADDED   = 3'd0;
   localparam logic [2:0] EVT_TOKEN_DROPPED = 3'd1;
   localparam logic [2:0] EVT_TOO_LARGE     = 3'd2;
   localparam logic [2:0] EVT_QUEUED        = 3'd3;
   localparam logic [2:0] EVT_PASSED        = 3'd4;
   localparam logic [2:0] EVT_QUEUE_FULL    = 3'd5;

   localparam logic ACT_TOKEN  = 1'b0;
   localparam logic ACT_PACKET = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] need;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

// File: design/token_bucket_packet_shaper.sv
// Top level of the token bucket packet shaper.
// A transaction is accepted when start is high and busy is low,
// and in the following cycle the head of the waiting queue, read from the queue memory during
// the accept cycle, is checked against the bucket and the queue and bucket are updated. The
// result appears with rsp_valid high for exactly one cycle right after that, and the receiver
// cannot stall it; a new transaction can be accepted in that same cycle, but not while one
// is executing. The bucket depth register may be written at any time the block
// is idle and takes effect for the next transaction.
`include "assert_macros.svh"

module token_bucket_packet_shaper #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_packet_id,
   input  logic [15:0] req_tokens_needed,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_released_valid,
   output logic [15:0] rsp_released_id,
   output logic [15:0] rsp_bucket_level,
   output logic [6:0]  rsp_queue_fill,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tbps_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [15:0] depth_ff;
   logic [15:0] tokens_ff, tokens_in;

   logic        act_ff;
   logic [15:0] id_ff;
   logic [15:0] need_ff;

   logic        rsp_valid_ff;
   logic [2:0]  evt_ff, evt_in;
   logic        rel_valid_ff, rel_valid_in;
   logic [15:0] rel_id_ff, rel_id_in;
   logic [6:0]  fill_ff;

   logic             exec;
   logic             push_c, pop_c;
   logic [15:0]      level_add;
   logic [CNT_W-1:0] q_count, count_after;

   q_ctrl_type q_ctrl;
   q_stat_type q_stat;
   entry_type  head_entry;
   entry_type  push_entry;

   tbps_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .push_entry (push_entry),
      .head_entry (head_entry),
      .stat       (q_stat),
      .count      (q_count)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign exec = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         act_ff  <= req_action;
         id_ff   <= req_packet_id;
         need_ff <= req_tokens_needed;
      end
   end

   // Decision for the transaction held in the item registers.
   always_comb begin
      level_add    = (tokens_ff < depth_ff) ? tokens_ff + 16'd1 : tokens_ff;
      tokens_in    = tokens_ff;
      evt_in       = EVT_TOKEN_ADDED;
      rel_valid_in = 1'b0;
      rel_id_in    = '0;
      push_c       = 1'b0;
      pop_c        = 1'b0;
      if (act_ff == ACT_TOKEN) begin
         evt_in    = (tokens_ff < depth_ff) ? EVT_TOKEN_ADDED : EVT_TOKEN_DROPPED;
         tokens_in = level_add;
         if (!q_stat.empty && level_add >= head_entry.need) begin
            tokens_in    = level_add - head_entry.need;
            rel_valid_in = 1'b1;
            rel_id_in    = head_entry.id;
            pop_c        = 1'b1;
         end
      end else begin
         if (need_ff > depth_ff) begin
            evt_in = EVT_TOO_LARGE;
         end else if (q_stat.empty && tokens_ff >= need_ff) begin
            tokens_in    = tokens_ff - need_ff;
            rel_valid_in = 1'b1;
            rel_id_in    = id_ff;
            evt_in       = EVT_PASSED;
         end else if (q_stat.full) begin
            evt_in = EVT_QUEUE_FULL;
         end else begin
            push_c = 1'b1;
            evt_in = EVT_QUEUED;
         end
      end
   end

   assign q_ctrl.push     = exec && push_c;
   assign q_ctrl.pop      = exec && pop_c;
   assign push_entry.id   = id_ff;
   assign push_entry.need = need_ff;

   always_comb begin
      count_after = q_count;
      if (push_c) begin
         count_after = q_count + 1'b1;
      end else if (pop_c) begin
         count_after = q_count - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= BUCKET_DEPTH_RESET;
         tokens_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            depth_ff <= csr_wr_data;
         end
         if (exec) begin
            tokens_ff <= tokens_in;
         end
         rsp_valid_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         evt_ff       <= evt_in;
         rel_valid_ff <= rel_valid_in;
         rel_id_ff    <= rel_id_in;
         fill_ff      <= 7'(count_after);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = evt_ff;
   assign rsp_released_valid = rel_valid_ff;
   assign rsp_released_id    = rel_id_ff;
   assign rsp_bucket_level   = tokens_ff;
   assign rsp_queue_fill     = fill_ff;

   `ASSERT_HOLDS(a_rsp_after_exec, clock, reset, rsp_valid_ff |-> $past(state_ff) == ST_EXEC, "result without execute cycle")
   `ASSERT_HOLDS(a_tick_release_nonempty, clock, reset, (exec && act_ff == ACT_TOKEN && rel_valid_in) |-> !q_stat.empty, "release from empty queue")
   `ASSERT_HOLDS(a_queued_not_full, clock, reset, (exec && evt_in == EVT_QUEUED) |=> !$past(q_stat.full), "packet queued into full queue")

endmodule

// File: design/tbps_queue.sv
// Waiting packet queue: memory, head and tail pointers, fill count.
`include "assert_macros.svh"

module tbps_queue #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tbps_pkg::q_ctrl_type                 ctrl,
   input  tbps_pkg::entry_type                  push_entry,
   output tbps_pkg::entry_type                  head_entry,
   output tbps_pkg::q_stat_type                 stat,
   output logic [$clog2(QUEUE_DEPTH + 1) - 1:0] count
);
   import tbps_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type mem [QUEUE_DEPTH];
   entry_type head_rd_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // The head entry is registered from memory every cycle; the controller only looks at it
   // once the pointers and memory have settled.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_entry;
      end
      head_rd_ff <= mem[head_ff];
   end

   always_comb begin
      head_in  = ctrl.pop  ? next_slot(head_ff) : head_ff;
      tail_in  = ctrl.push ? next_slot(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign head_entry = head_rd_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign count      = count_ff;

   `ASSERT_NEVER(a_no_push_full, clock, reset, ctrl.push && stat.full, "push into full queue")
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, ctrl.pop && stat.empty, "pop from empty queue")
   `ASSERT_NEVER(a_push_pop_excl, clock, reset, ctrl.push && ctrl.pop, "push and pop together")

endmodule

// File: bench/shaper_checker.sv
// Checker for the token bucket packet shaper: predicts each transaction and compares results.
module shaper_checker #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_packet_id,
   input  logic [15:0] req_tokens_needed,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_event_res,
   input  logic        rsp_released_valid,
   input  logic [15:0] rsp_released_id,
   input  logic [15:0] rsp_bucket_level,
   input  logic [6:0]  rsp_queue_fill,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          pending_count,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import tbps_pkg::*;

   typedef struct packed {
      logic [2:0]  event_res;
      logic        released_valid;
      logic [15:0] released_id;
      logic [15:0] bucket_level;
      logic [6:0]  queue_fill;
   } outcome_type;

   logic [15:0] depth_cfg;
   logic [15:0] tokens;
   entry_type   wait_line[$];
   outcome_type pending_outcomes[$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   // Applies one transaction to the shadow bucket and queue and returns its outcome.
   function automatic outcome_type shape_event(logic act, logic [15:0] id, logic [15:0] need);
      outcome_type o;
      entry_type   head;
      o = '0;
      if (act == ACT_TOKEN) begin
         if (tokens < depth_cfg) begin
            tokens = tokens + 16'd1;
            o.event_res = EVT_TOKEN_ADDED;
         end else begin
            o.event_res = EVT_TOKEN_DROPPED;
         end
         if (wait_line.size() != 0 && tokens >= wait_line[0].need) begin
            head = wait_line.pop_front();
            tokens = tokens - head.need;
            o.released_valid = 1'b1;
            o.released_id = head.id;
         end
      end else begin
         if (need > depth_cfg) begin
            o.event_res = EVT_TOO_LARGE;
         end else if (wait_line.size() == 0 && tokens >= need) begin
            tokens = tokens - need;
            o.released_valid = 1'b1;
            o.released_id = id;
            o.event_res = EVT_PASSED;
         end else if (wait_line.size() >= QUEUE_DEPTH) begin
            o.event_res = EVT_QUEUE_FULL;
         end else begin
            head.id = id;
            head.need = need;
            wait_line.push_back(head);
            o.event_res = EVT_QUEUED;
         end
      end
      o.bucket_level = tokens;
      o.queue_fill = 7'(wait_line.size());
      return o;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         depth_cfg = BUCKET_DEPTH_RESET;
         tokens = '0;
         wait_line.delete();
         pending_outcomes.delete();
      end else begin
         // A result always belongs to an earlier transaction, so compare before pushing.
         if (rsp_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               $error("result seen with no transaction outstanding");
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("event_res", 16'(want.event_res), 16'(rsp_event_res));
               check_field("released_valid", 16'(want.released_valid),
                           16'(rsp_released_valid));
               check_field("released_id", want.released_id, rsp_released_id);
               check_field("bucket_level", want.bucket_level, rsp_bucket_level);
               check_field("queue_fill", 16'(want.queue_fill), 16'(rsp_queue_fill));
            end
         end
         if (csr_wr_en) begin
            depth_cfg = csr_wr_data;
         end
         if (start && !busy) begin
            pending_outcomes.push_back(shape_event(req_action, req_packet_id,
                                                   req_tokens_needed));
         end
      end
      pending_count <= pending_outcomes.size();
   end

endmodule

// File: bench/tb_token_bucket_packet_shaper.sv
// Testbench top for the token bucket packet shaper: stimulus, clock, reset and verdict.
module tb_token_bucket_packet_shaper;
   timeunit 1ns;
   timeprecision 1ps;

   import tbps_pkg::*;

   localparam int ITEMS_PER_PHASE = 250;
   localparam int PHASE_COUNT = 8;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [15:0] req_packet_id;
   logic [15:0] req_tokens_needed;
   logic        rsp_valid;
   logic [2:0]  rsp_event_res;
   logic        rsp_released_valid;
   logic [15:0] rsp_released_id;
   logic [15:0] rsp_bucket_level;
   logic [6:0]  rsp_queue_fill;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          pending_count;
   int          fail_count;
   int          idle_pct;

   token_bucket_packet_shaper DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_packet_id      (req_packet_id),
      .req_tokens_needed  (req_tokens_needed),
      .rsp_valid          (rsp_valid),
      .rsp_event_res      (rsp_event_res),
      .rsp_released_valid (rsp_released_valid),
      .rsp_released_id    (rsp_released_id),
      .rsp_bucket_level   (rsp_bucket_level),
      .rsp_queue_fill     (rsp_queue_fill),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   shaper_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_packet_id      (req_packet_id),
      .req_tokens_needed  (req_tokens_needed),
      .rsp_valid          (rsp_valid),
      .rsp_event_res      (rsp_event_res),
      .rsp_released_valid (rsp_released_valid),
      .rsp_released_id    (rsp_released_id),
      .rsp_bucket_level   (rsp_bucket_level),
      .rsp_queue_fill     (rsp_queue_fill),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .pending_count      (pending_count),
      .fail_count         (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Start stays high from one transaction to the next unless a gap is inserted.
   task automatic send_item(logic act, logic [15:0] id, logic [15:0] need);
      req_action <= act;
      req_packet_id <= id;
      req_tokens_needed <= need;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   task automatic write_depth(logic [15:0] value);
      wait_quiet();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small needs so ticks keep the queue moving; wide needs that can queue only late,
   // since one of them at the head stalls the queue for the rest of the run.
   function automatic logic [15:0] pick_need(logic [15:0] depth, bit wide_ok);
      int r;
      int cap;
      r = $urandom_range(99);
      cap = (depth < 8) ? depth : 8;
      if (r < 6 && depth < 16'hFFFF) return 16'($urandom_range(depth + 1, 65535));
      if (r < 9) return 16'd0;
      if (r < 14) begin
         if (wide_ok) return 16'($urandom);
         cap = (depth < 40) ? depth : 40;
      end
      return 16'($urandom_range(1, cap));
   endfunction

   initial begin
      int unsigned depth_plan[PHASE_COUNT];
      int burst_left;
      int tick_pct;
      int sent;
      logic act;
      depth_plan = '{1, 2, 4, 7, 10, 300, 65535, 65535};
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_TOKEN;
      req_packet_id = '0;
      req_tokens_needed = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_pct = 0;
      burst_left = 0;
      tick_pct = 50;
      sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset depth: zero need, oversize, queueing behind waiting packets, releases.
      send_item(ACT_PACKET, 16'hFFFF, 16'd0);
      send_item(ACT_PACKET, 16'h0000, 16'd11);
      send_item(ACT_PACKET, 16'hAAAA, 16'hFFFF);
      send_item(ACT_PACKET, 16'h1111, 16'd3);
      send_item(ACT_PACKET, 16'h2222, 16'd1);
      repeat (4) send_item(ACT_TOKEN, 16'h5555, 16'hFFFF);
      send_item(ACT_PACKET, 16'h3333, 16'd2);
      send_item(ACT_TOKEN, 16'h0000, 16'h0000);
      // The bucket covers this one, but it must still wait behind the head.
      send_item(ACT_PACKET, 16'h4444, 16'd1);
      repeat (13) send_item(ACT_TOKEN, 16'($urandom), 16'($urandom));

      // Depth lowered below the level held: tokens stay, ticks drop.
      write_depth(16'd3);
      send_item(ACT_TOKEN, 16'h0000, 16'h0000);
      send_item(ACT_PACKET, 16'h0000, 16'd3);
      send_item(ACT_TOKEN, 16'hFFFF, 16'hFFFF);

      // Zero depth: every tick drops and only a zero need passes.
      write_depth(16'd0);
      send_item(ACT_TOKEN, 16'h1234, 16'h0001);
      send_item(ACT_PACKET, 16'h8001, 16'd1);
      send_item(ACT_PACKET, 16'hFFFF, 16'd0);

      // Depths never fall from phase to phase so waiting packets can always be served.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_depth(16'(depth_plan[p]));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(2))
                  0: tick_pct = 15;
                  1: tick_pct = 50;
                  default: tick_pct = 85;
               endcase
            end
            burst_left--;
            if (sent < 667) idle_pct = 38;
            else if (sent < 1333) idle_pct = 46;
            else idle_pct = 0;
            act = ($urandom_range(99) < tick_pct) ? ACT_TOKEN : ACT_PACKET;
            if (act == ACT_TOKEN)
               send_item(act, 16'($urandom), 16'($urandom));
            else
               send_item(act, 16'($urandom),
                         pick_need(16'(depth_plan[p]), p == PHASE_COUNT - 1));
            sent++;
         end
      end

      wait_quiet();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
